// ===== sv/hrbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants for the half-resolution Bayer demosaic block.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int BYTE_W        = 8;
    localparam int GAIN_W        = 16;
    localparam int HALF_WIDTH_W  = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam int DEFAULT_MAX_HALF_WIDTH = 2048;
    localparam int DEFAULT_GAIN_FRAC_BITS = 12;

    localparam logic [HALF_WIDTH_W-1:0] RST_HALF_WIDTH = 12'd640;
    localparam logic [GAIN_W-1:0]       RST_GAIN       = 16'd4096;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH   = 3'd0,
        CFG_WIDE_SAMPLES = 3'd1,
        CFG_RGB_ORDER    = 3'd2,
        CFG_GAIN_ENABLE  = 3'd3,
        CFG_RED_GAIN     = 3'd4,
        CFG_GREEN_GAIN   = 3'd5,
        CFG_BLUE_GAIN    = 3'd6
    } t_cfg_idx;

    // Mode bits that the channel gain stage needs
    typedef struct packed {
        logic wide;
        logic gain_en;
    } t_chan_mode;

endpackage : hrbd_pkg

`default_nettype wire

// ===== sv/hrbd_chan.sv =====
// ----------------------------------------------------------------------------
// hrbd_chan
// One color channel: registered gain product, then floor and saturation to
// the sample maximum (registered sample with gain off) and byte selection.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbd_chan
    import hrbd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEFAULT_GAIN_FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [SAMPLE_W-1:0] i_value,
    input  wire logic [GAIN_W-1:0]   i_gain,
    input  wire t_chan_mode          i_mode,
    output logic      [BYTE_W-1:0]   o_byte
);

    localparam int PROD_W = SAMPLE_W + GAIN_W;

    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_value;
    logic [SAMPLE_W-1:0] w_in;
    logic [PROD_W-1:0]   w_scaled;
    logic [SAMPLE_W-1:0] w_max;
    logic [SAMPLE_W-1:0] w_sat;
    logic [SAMPLE_W-1:0] w_sel;

    // drop the upper sample bits in 8-bit mode
    assign w_in = i_mode.wide ? i_value : {{(SAMPLE_W-BYTE_W){1'b0}}, i_value[BYTE_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(w_in) * PROD_W'(i_gain);
            r_value <= w_in;
        end
    end

    always_comb begin
        w_scaled = r_prod >> GAIN_FRAC_BITS;
        w_max    = i_mode.wide ? {SAMPLE_W{1'b1}} : SAMPLE_W'(8'hFF);
        w_sat    = (w_scaled > PROD_W'(w_max)) ? w_max : w_scaled[SAMPLE_W-1:0];
        w_sel    = i_mode.gain_en ? w_sat : r_value;
        o_byte   = i_mode.wide ? w_sel[SAMPLE_W-1:SAMPLE_W-BYTE_W] : w_sel[BYTE_W-1:0];
    end

endmodule : hrbd_chan

`default_nettype wire

// ===== sv/half_res_bayer_demosaic_gain.sv =====
// ----------------------------------------------------------------------------
// half_res_bayer_demosaic_gain
// RGGB Bayer stream to half-resolution RGB with optional per-channel gain.
// ----------------------------------------------------------------------------
// The block takes one raw sample per clock, unless the output stalls, with no
// bubbles of its own and emits one 24-bit pixel per 2x2 quad, on the beat of
// the quad's blue sample; the pixel passes stage 1, stage 2 and the output
// register. The even row's red and green go into a single-port line memory of
// MAX_HALF_WIDTH x 32 bits; one access per accepted sample (a write on the
// even row's green, a read on the odd row's blue) keeps the rate at one
// sample per cycle. tuser on the input marks the first sample of a frame.
// tlast on the output marks the last pixel of an output row.
// ----------------------------------------------------------------------------
`default_nettype none

module half_res_bayer_demosaic_gain
    import hrbd_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = DEFAULT_MAX_HALF_WIDTH,
    parameter int GAIN_FRAC_BITS = DEFAULT_GAIN_FRAC_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // sample stream
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [SAMPLE_W-1:0]     i_s_tdata,  // [15:0] sample
    input  wire logic                    i_s_tuser,  // [0] frame_start
    // pixel stream
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [3*BYTE_W-1:0]          o_m_tdata,  // [7:0] first, [15:8] middle,
                                                     // [23:16] last byte
    output logic                         o_m_tlast   // row_end
);

    localparam int AW    = $clog2(MAX_HALF_WIDTH);
    localparam int WW    = ($clog2(MAX_HALF_WIDTH + 1) > HALF_WIDTH_W) ?
                           $clog2(MAX_HALF_WIDTH + 1) : HALF_WIDTH_W;
    localparam int MEM_W = 2 * SAMPLE_W;

    // configuration registers
    logic [HALF_WIDTH_W-1:0] r_half_width;
    logic                    r_wide;
    logic                    r_rgb_order;
    logic                    r_gain_en;
    logic [GAIN_W-1:0]       r_red_gain;
    logic [GAIN_W-1:0]       r_green_gain;
    logic [GAIN_W-1:0]       r_blue_gain;

    // position state
    logic [HALF_WIDTH_W-1:0] r_col, n_col;
    logic                    r_col_odd, n_col_odd;
    logic                    r_row_odd, n_row_odd;
    logic [SAMPLE_W-1:0]     r_held_red, n_held_red;

    logic [MEM_W-1:0]        r_mem [MAX_HALF_WIDTH];

    // pipeline
    logic                    r1_valid;
    logic [SAMPLE_W-1:0]     r1_blue;
    logic                    r1_last;
    logic [MEM_W-1:0]        r1_rd;
    logic                    r2_valid;
    logic                    r2_last;
    logic                    r_out_valid;
    logic [3*BYTE_W-1:0]     r_out_data;
    logic                    r_out_last;

    logic                    w_en1, w_en2, w_en3;
    logic                    w_accept;
    logic [SAMPLE_W-1:0]     w_sample;
    logic [HALF_WIDTH_W-1:0] w_col;
    logic                    w_col_odd;
    logic                    w_row_odd;
    logic [WW-1:0]           w_hw_ext;
    logic [WW-1:0]           w_eff;
    logic [WW-1:0]           w_last_col;
    logic                    w_last;
    logic [AW+HALF_WIDTH_W-1:0] w_col_cat;
    logic [AW-1:0]           w_addr;
    logic                    w_mem_we;
    logic                    w_mem_re;
    logic                    w_emit;
    t_chan_mode              w_mode;
    logic [BYTE_W-1:0]       w_red_byte, w_green_byte, w_blue_byte;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= RST_HALF_WIDTH;
            r_wide       <= 1'b1;
            r_rgb_order  <= 1'b1;
            r_gain_en    <= 1'b0;
            r_red_gain   <= RST_GAIN;
            r_green_gain <= RST_GAIN;
            r_blue_gain  <= RST_GAIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HALF_WIDTH:   r_half_width <= i_cfg_data[HALF_WIDTH_W-1:0];
                CFG_WIDE_SAMPLES: r_wide       <= i_cfg_data[0];
                CFG_RGB_ORDER:    r_rgb_order  <= i_cfg_data[0];
                CFG_GAIN_ENABLE:  r_gain_en    <= i_cfg_data[0];
                CFG_RED_GAIN:     r_red_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_GREEN_GAIN:   r_green_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_BLUE_GAIN:    r_blue_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign w_en3      = !r_out_valid || i_m_tready;
    assign w_en2      = !r2_valid || w_en3;
    assign w_en1      = !r1_valid || w_en2;
    assign o_s_tready = w_en1;
    assign w_accept   = i_s_tvalid && w_en1;

    // ---------------- position and line memory access ----------------
    always_comb begin
        w_sample  = r_wide ? i_s_tdata : {8'h00, i_s_tdata[BYTE_W-1:0]};
        // frame start restarts row and column before this sample is used
        w_col     = i_s_tuser ? '0   : r_col;
        w_col_odd = i_s_tuser ? 1'b0 : r_col_odd;
        w_row_odd = i_s_tuser ? 1'b0 : r_row_odd;

        w_hw_ext  = WW'(r_half_width);
        if (w_hw_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_hw_ext > WW'(MAX_HALF_WIDTH)) begin
            w_eff = WW'(MAX_HALF_WIDTH);
        end else begin
            w_eff = w_hw_ext;
        end
        w_last_col = w_eff - WW'(1);
        w_last     = WW'(w_col) >= w_last_col;

        w_col_cat = {{AW{1'b0}}, w_col};
        w_addr    = w_col_cat[AW-1:0];
        w_mem_we  = w_accept && !w_row_odd && w_col_odd;
        w_emit    = w_row_odd && w_col_odd;
        w_mem_re  = w_accept && w_emit;

        n_col      = r_col;
        n_col_odd  = r_col_odd;
        n_row_odd  = r_row_odd;
        n_held_red = r_held_red;
        if (w_accept) begin
            if (!w_row_odd && !w_col_odd) begin
                n_held_red = w_sample;
            end
            if (w_col_odd) begin
                n_col_odd = 1'b0;
                if (w_last) begin
                    n_col     = '0;
                    n_row_odd = !w_row_odd;
                end else begin
                    n_col     = w_col + HALF_WIDTH_W'(1);
                    n_row_odd = w_row_odd;
                end
            end else begin
                n_col_odd = 1'b1;
                n_col     = w_col;
                n_row_odd = w_row_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_col_odd  <= 1'b0;
            r_row_odd  <= 1'b0;
            r_held_red <= '0;
        end else begin
            r_col      <= n_col;
            r_col_odd  <= n_col_odd;
            r_row_odd  <= n_row_odd;
            r_held_red <= n_held_red;
        end
    end

    // red in the low half, green in the high half
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_addr] <= {w_sample, r_held_red};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r1_rd <= r_mem[w_addr];
        end
    end

    // ---------------- stage 1: blue beat and line data ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en1) begin
            r1_valid <= w_accept && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_blue <= w_sample;
            r1_last <= w_last;
        end
    end

    // ---------------- stage 2: gain products ----------------
    assign w_mode = '{wide: r_wide, gain_en: r_gain_en};

    hrbd_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_red (
        .i_clk   (i_clk),
        .i_en    (w_en2),
        .i_value (r1_rd[SAMPLE_W-1:0]),
        .i_gain  (r_red_gain),
        .i_mode  (w_mode),
        .o_byte  (w_red_byte)
    );

    hrbd_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_green (
        .i_clk   (i_clk),
        .i_en    (w_en2),
        .i_value (r1_rd[MEM_W-1:SAMPLE_W]),
        .i_gain  (r_green_gain),
        .i_mode  (w_mode),
        .o_byte  (w_green_byte)
    );

    hrbd_chan #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_blue (
        .i_clk   (i_clk),
        .i_en    (w_en2),
        .i_value (r1_blue),
        .i_gain  (r_blue_gain),
        .i_mode  (w_mode),
        .o_byte  (w_blue_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_last <= r1_last;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out_data <= r_rgb_order ? {w_blue_byte, w_green_byte, w_red_byte}
                                      : {w_red_byte, w_green_byte, w_blue_byte};
            r_out_last <= r2_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule : half_res_bayer_demosaic_gain

`default_nettype wire
